// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// signal must never be unknown outside reset
`define ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error(msg);

`endif

// ===== hw/rtl/qtbht_pkg.sv =====
// shared types and constants for the quotient tag bucket hash table
package qtbht_pkg;

    localparam int KEY_W   = 64;
    localparam int TAG_W   = 40;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 11;
    localparam int BIDX_W  = 10;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // handshake between top level and the divider
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [KEY_W-1:0]  quotient;
        logic [CNT_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ===== hw/rtl/qtbht_ram.sv =====
// generic single-port-write, single-read synchronous ram with registered read
module qtbht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/qtbht_div.sv =====
// restoring radix-2 divider, one quotient bit per cycle
module qtbht_div (
    input  logic                clk,
    input  logic                rst_n,
    input  qtbht_pkg::div_req_t req,
    output qtbht_pkg::div_rsp_t rsp
);

    localparam int KW = qtbht_pkg::KEY_W;
    localparam int CW = qtbht_pkg::CNT_W;

    logic [KW-1:0]        quo_reg, quo_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        dvs_reg, dvs_next;
    logic [$clog2(KW):0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW:0]          trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[KW-1]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor so it fits CW bits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = CW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[KW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CW-1:0];
                quo_next = {quo_reg[KW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(KW)+1)'(KW-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/quotient_tag_bucket_hash_table.sv =====
// top level of the quotient tag bucket hash table
//
//  channel  | ports                                           | handshake
//  ---------+-------------------------------------------------+------------------
//  command  | command, kmer_key, new_value                    | start & !busy
//  result   | status, stored_value, bucket_index              | done, one cycle
//  config   | cfg_data                                        | cfg_we
//
// one word goes through the bit-serial divider, then the handoff and the fill
// read, then a compare for each entry walked; the bit-serial divider and the
// single read port of the entry memories set how long a word takes; busy drops
// as the result shows
// after reset the bucket fill memory is cleared one bucket a cycle with busy
// high; config writes are taken throughout
// the receiver cannot stall: a result shows for one cycle with done high
`include "assert_macros.svh"

module quotient_tag_bucket_hash_table #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             command,
    input  logic [qtbht_pkg::KEY_W-1:0]      kmer_key,
    input  logic [qtbht_pkg::VALUE_W-1:0]    new_value,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [qtbht_pkg::VALUE_W-1:0]    stored_value,
    output logic [qtbht_pkg::BIDX_W-1:0]     bucket_index,
    input  logic                             cfg_we,
    input  logic [qtbht_pkg::CNT_W-1:0]      cfg_data
);

    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW     = $clog2(WAYS + 1);
    localparam int EW     = BW + WW;
    localparam int CW     = qtbht_pkg::CNT_W;
    localparam int TW     = qtbht_pkg::TAG_W;
    localparam int VW     = qtbht_pkg::VALUE_W;
    localparam int XW     = qtbht_pkg::BIDX_W;
    localparam int MAXCNT = (BUCKETS < 1024) ? BUCKETS : 1024;

    // state codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [BW-1:0] clr_reg, clr_next;
    logic          cmd_reg;
    logic [VW-1:0] val_reg;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [TW-1:0] tag_reg, tag_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] way_reg, way_next;
    logic          done_reg, done_next;
    logic [1:0]    st_reg, st_next;
    logic [VW-1:0] sval_reg, sval_next;

    // divisor clamped to 1..min(BUCKETS,1024)
    logic [CW-1:0] divisor;
    always_comb
    begin
        divisor = count_reg;
        if (count_reg == '0)
        begin
            divisor = CW'(1);
        end
        else if (count_reg > CW'(MAXCNT))
        begin
            divisor = CW'(MAXCNT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1024);
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    // divider
    qtbht_pkg::div_req_t div_req;
    qtbht_pkg::div_rsp_t div_rsp;
    assign div_req.start    = start && !busy;
    assign div_req.dividend = kmer_key;
    assign div_req.divisor  = divisor;

    qtbht_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // memories
    logic          fill_we;
    logic [BW-1:0] fill_waddr, fill_raddr;
    logic [FW-1:0] fill_wdata, fill_rdata;
    logic          ent_we;
    logic [EW-1:0] ent_waddr, ent_raddr;
    logic [TW-1:0] tag_rdata;
    logic [VW-1:0] val_rdata;

    qtbht_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    qtbht_ram #(.WIDTH(TW), .DEPTH(BUCKETS*WAYS)) u_tag_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (tag_reg),
        .raddr (ent_raddr),
        .rdata (tag_rdata)
    );

    qtbht_ram #(.WIDTH(VW), .DEPTH(BUCKETS*WAYS)) u_val_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (val_reg),
        .raddr (ent_raddr),
        .rdata (val_rdata)
    );

    // entry address from bucket and way
    function automatic logic [EW-1:0] slot_addr(input logic [BW-1:0] b,
                                                input logic [FW-1:0] w);
        logic [EW-1:0] a;
        a = EW'(b) * EW'(WAYS) + EW'(w);
        return a;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        bkt_next   = bkt_reg;
        tag_next   = tag_reg;
        fill_next  = fill_reg;
        way_next   = way_reg;
        done_next  = 1'b0;
        st_next    = st_reg;
        sval_next  = sval_reg;
        fill_we    = 1'b0;
        fill_waddr = bkt_reg;
        fill_wdata = fill_reg + 1'b1;
        fill_raddr = bkt_reg;
        ent_we     = 1'b0;
        ent_waddr  = slot_addr(bkt_reg, fill_reg);
        ent_raddr  = slot_addr(bkt_reg, way_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep the fill memory to zero
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS-1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    bkt_next   = BW'(div_rsp.remainder);
                    tag_next   = div_rsp.quotient[TW-1:0];
                    way_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                // fill read address is bkt_reg, data lands next cycle
                state_next = S_READ;
            end
            S_READ:
            begin
                fill_next = (fill_rdata > FW'(WAYS)) ? FW'(WAYS) : fill_rdata;
                if (way_reg < fill_next)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                // entry at way_reg was read last cycle
                if (tag_rdata == tag_reg)
                begin
                    st_next    = qtbht_pkg::ST_FOUND;
                    sval_next  = val_rdata;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    way_next = way_reg + 1'b1;
                    ent_raddr = slot_addr(bkt_reg, way_reg + 1'b1);
                    if (way_reg + 1'b1 < fill_reg)
                    begin
                        state_next = S_CMP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                // miss path
                done_next  = 1'b1;
                state_next = S_IDLE;
                sval_next  = '0;
                if (cmd_reg == qtbht_pkg::CMD_FIND)
                begin
                    st_next = qtbht_pkg::ST_MISSING;
                end
                else if (fill_reg >= FW'(WAYS))
                begin
                    st_next = qtbht_pkg::ST_FULL;
                end
                else
                begin
                    st_next   = qtbht_pkg::ST_INSERTED;
                    sval_next = val_reg;
                    ent_we    = 1'b1;
                    fill_we   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= command;
            val_reg <= new_value;
        end
        bkt_reg  <= bkt_next;
        tag_reg  <= tag_next;
        fill_reg <= fill_next;
        way_reg  <= way_next;
        st_reg   <= st_next;
        sval_reg <= sval_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = st_reg;
    assign stored_value = sval_reg;
    assign bucket_index = XW'(bkt_reg);

    // a result only follows work in flight
    `ASSERT_CLK(a_done_after_work, clk, rst_n, done |-> $past(busy), "done without work")
    // an insert writes the fill memory below the way limit
    `ASSERT_CLK(a_fill_limit, clk, rst_n, fill_we && state_reg != S_CLEAR |-> fill_reg < FW'(WAYS), "fill overflow")
    // an entry write only comes with an add
    `ASSERT_CLK(a_write_add, clk, rst_n, ent_we |-> cmd_reg == qtbht_pkg::CMD_ADD, "write on find")

endmodule
